// ===== design/lfuc_pkg.sv =====
package lfuc_pkg;

  localparam int CfgW   = 5;
  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int CountW = 32;
  localparam int StampW = 64;

  localparam logic [CfgW-1:0]   CapReset  = 5'd16;
  localparam logic [ValW-1:0]   MissValue = '1;
  localparam logic [CountW-1:0] CountOne  = 32'd1;
  localparam logic [CountW-1:0] CountMax  = '1;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic signed [KeyW-1:0] lookup_key;
    logic signed [ValW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                   key_hit;
    logic signed [ValW-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic free_found;
    logic vic_found;
  } scan_flags_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite
  } state_e;

endpackage

// ===== design/lfuc_scan.sv =====
module lfuc_scan import lfuc_pkg::*; #(
  parameter int IdxW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            chk_en_i,
  input  logic [IdxW-1:0] chk_idx_i,
  input  logic            chk_valid_i,
  input  entry_t          entry_i,
  input  logic [KeyW-1:0] key_i,
  output scan_flags_t     flags_o,
  output logic [IdxW-1:0] hit_idx_o,
  output logic [IdxW-1:0] free_idx_o,
  output logic [IdxW-1:0] vic_idx_o,
  output entry_t          hit_entry_o
);

  scan_flags_t       flags_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q, vic_idx_q;
  entry_t            hit_ent_q;
  logic [CountW-1:0] vic_cnt_q;
  logic [StampW-1:0] vic_stamp_q;

  logic is_hit, is_free, is_vic;

  always_comb begin
    is_hit  = chk_valid_i && (entry_i.key == key_i) && !flags_q.hit;
    is_free = !chk_valid_i && !flags_q.free_found;
    is_vic  = chk_valid_i && (!flags_q.vic_found || (entry_i.count < vic_cnt_q) ||
              ((entry_i.count == vic_cnt_q) && (entry_i.stamp < vic_stamp_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (start_i) begin
      flags_q <= '0;
    end else if (chk_en_i) begin
      if (is_hit)  flags_q.hit        <= 1'b1;
      if (is_free) flags_q.free_found <= 1'b1;
      if (is_vic)  flags_q.vic_found  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_en_i) begin
      if (is_hit) begin
        hit_idx_q <= chk_idx_i;
        hit_ent_q <= entry_i;
      end
      if (is_free) free_idx_q <= chk_idx_i;
      if (is_vic) begin
        vic_idx_q   <= chk_idx_i;
        vic_cnt_q   <= entry_i.count;
        vic_stamp_q <= entry_i.stamp;
      end
    end
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign free_idx_o  = free_idx_q;
  assign vic_idx_o   = vic_idx_q;
  assign hit_entry_o = hit_ent_q;

endmodule

// ===== design/lfu_cache_table_core.sv =====
// Fully associative key-value cache with least-frequently-used replacement, ties broken
// by least recent use. Each item is a get or a put; every item returns one result with
// key_hit and read_value (-1 on a miss and for every put). Entries live in one
// entry memory with a registered read and its own write port; each item passes through
// an accept step, one memory read per entry to match the key and pick the victim, and
// a write-back step. The result sits in an output register, so the next item can be
// accepted while it waits. Valid bits and the fill count clear at reset; entry contents
// need no clearing pass. The capacity register may be written at any time the block is
// idle and is limited to CAPACITY; zero turns puts into no-ops.
module lfu_cache_table_core import lfuc_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_data_o
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  state_e            state_q, state_d;
  logic [CfgW-1:0]   cap_q;
  logic [CntW-1:0]   used_q;
  logic [StampW-1:0] stamp_q;
  logic [CAPACITY-1:0] valid_q;
  logic [IdxW-1:0]   chk_idx_q;
  req_t              req_q;
  logic              out_valid_q;
  rsp_t              out_data_q;

  entry_t            mem_q [CAPACITY];
  entry_t            rd_q;

  logic              scan_start, chk_en, mem_we, set_valid, used_inc, out_load;
  logic [IdxW-1:0]   rd_addr, wr_idx;
  entry_t            wr_ent;
  rsp_t              rsp_d;

  scan_flags_t       flags;
  logic [IdxW-1:0]   hit_idx, free_idx, vic_idx;
  entry_t            hit_ent;

  logic [CmpW-1:0]   cap_ext, cap_lim, cap_eff, used_ext;

  assign cap_ext  = CmpW'(cap_q);
  assign cap_lim  = CmpW'(CAPACITY);
  assign cap_eff  = (cap_ext < cap_lim) ? cap_ext : cap_lim;
  assign used_ext = CmpW'(used_q);

  lfuc_scan #(
    .IdxW(IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .chk_en_i    (chk_en),
    .chk_idx_i   (chk_idx_q),
    .chk_valid_i (valid_q[chk_idx_q]),
    .entry_i     (rd_q),
    .key_i       (req_q.lookup_key),
    .flags_o     (flags),
    .hit_idx_o   (hit_idx),
    .free_idx_o  (free_idx),
    .vic_idx_o   (vic_idx),
    .hit_entry_o (hit_ent)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    scan_start = 1'b0;
    chk_en     = 1'b0;
    rd_addr    = '0;
    mem_we     = 1'b0;
    wr_idx     = hit_idx;
    wr_ent     = hit_ent;
    set_valid  = 1'b0;
    used_inc   = 1'b0;
    out_load   = 1'b0;
    rsp_d      = '{key_hit: flags.hit, read_value: MissValue};
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          scan_start = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        chk_en  = 1'b1;
        rd_addr = (chk_idx_q == LastIdx) ? '0 : chk_idx_q + 1'b1;
        if (chk_idx_q == LastIdx) state_d = StWrite;
      end
      StWrite: begin
        if (!out_valid_q || out_ready_i) begin
          out_load     = 1'b1;
          state_d      = StIdle;
          wr_ent.count = (hit_ent.count == CountMax) ? hit_ent.count : hit_ent.count + 1'b1;
          wr_ent.stamp = stamp_q;
          if (req_q.opcode == OpGet) begin
            if (flags.hit) begin
              mem_we           = 1'b1;
              rsp_d.read_value = hit_ent.value;
            end
          end else if (cap_eff != '0) begin
            if (flags.hit) begin
              mem_we       = 1'b1;
              wr_ent.value = req_q.write_value;
            end else begin
              wr_ent = '{key: req_q.lookup_key, value: req_q.write_value,
                         count: CountOne, stamp: stamp_q};
              if (used_ext < cap_eff) begin
                if (flags.free_found) begin
                  mem_we    = 1'b1;
                  wr_idx    = free_idx;
                  set_valid = 1'b1;
                  used_inc  = 1'b1;
                end
              end else if (flags.vic_found) begin
                mem_we = 1'b1;
                wr_idx = vic_idx;
              end
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapReset;
      used_q      <= '0;
      stamp_q     <= '0;
      valid_q     <= '0;
      chk_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (scan_start) begin
        chk_idx_q <= '0;
      end else if (chk_en) begin
        chk_idx_q <= chk_idx_q + 1'b1;
      end
      if (mem_we) stamp_q <= stamp_q + 1'b1;
      if (set_valid) valid_q[wr_idx] <= 1'b1;
      if (used_inc) used_q <= used_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_start) req_q <= in_data_i;
    if (out_load) out_data_q <= rsp_d;
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_idx] <= wr_ent;
    rd_q <= mem_q[rd_addr];
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CntW'($countones(valid_q)))
    else $error("fill count disagrees with valid bits");

  a_written_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(wr_idx)])
    else $error("entry written to a slot that is not valid");

  a_scan_runs_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && chk_idx_q != LastIdx) |=> state_q == StScan)
    else $error("scan left before the last entry");

  a_write_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StWrite && out_load))
    else $error("entry memory written outside write-back");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import lfuc_pkg::*;

  localparam int Slots     = 16;
  localparam int DirRows   = 24;
  localparam int Phases    = 10;
  localparam int PhaseReqs = 125;
  localparam int HoldLen   = 400;
  localparam int CycleCap  = 400000;

  typedef struct packed {
    logic            set_cap;
    logic [CfgW-1:0] cap;
    logic            op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic            typed;
    logic            hit;
    logic [ValW-1:0] rd;
  } drow_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  req_t            in_data;
  logic            out_valid;
  logic            out_ready;
  rsp_t            out_data;

  // cache image
  logic                ent_valid [Slots];
  logic [KeyW-1:0]     ent_key   [Slots];
  logic [ValW-1:0]     ent_value [Slots];
  logic [CountW-1:0]   ent_count [Slots];
  logic [StampW-1:0]   ent_stamp [Slots];
  int                  used_slots;
  logic [StampW-1:0]   stamp_ctr;
  logic [CfgW-1:0]     cap_reg;

  rsp_t    pending_lookups [$];
  rsp_t    due_rsp;
  int      mismatches;
  longint  cycle_cnt;
  bit      burst;
  bit      hold_long;

  logic [KeyW-1:0] key_pool [24];

  logic [CfgW-1:0] phase_cap [Phases] = '{5'd31, 5'd0, 5'd16, 5'd3, 5'd1,
                                          5'd8, 5'd0, 5'd2, 5'd16, 5'd5};

  drow_t dir_tab [DirRows] = '{
    '{1'b0, 5'd0,  OpGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7fff_ffff},
    '{1'b0, 5'd0,  OpGet, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b0, 5'd0,  OpGet, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
    '{1'b0, 5'd0,  OpPut, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
    '{1'b1, 5'd2,  OpPut, 32'h0000_0005, 32'ha5a5_a5a5, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, MissValue},
    '{1'b1, 5'd0,  OpPut, 32'h0000_0055, 32'h0000_0001, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_0055, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'h0000_0000, 32'h0000_0009, 1'b1, 1'b1, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, MissValue},
    '{1'b1, 5'd31, OpPut, 32'h0000_ffff, 32'hffff_0000, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpPut, 32'hffff_0000, 32'h0000_ffff, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_ffff, 32'h0000_0000, 1'b0, 1'b0, MissValue},
    '{1'b1, 5'd1,  OpPut, 32'h1357_9bdf, 32'h2468_ace0, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h1357_9bdf, 32'h0000_0000, 1'b0, 1'b0, MissValue},
    '{1'b0, 5'd0,  OpGet, 32'h0000_ffff, 32'h0000_0000, 1'b0, 1'b0, MissValue}
  };

  lfu_cache_table_core #(
    .CAPACITY(Slots)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_gap();
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void bump_entry(int s);
    if (ent_count[s] != CountMax) ent_count[s] = ent_count[s] + 1'b1;
    ent_stamp[s] = stamp_ctr;
    stamp_ctr = stamp_ctr + 1'b1;
  endfunction

  function automatic void load_entry(int s, req_t r);
    ent_valid[s] = 1'b1;
    ent_key[s]   = r.lookup_key;
    ent_value[s] = r.write_value;
    ent_count[s] = CountOne;
    ent_stamp[s] = stamp_ctr;
    stamp_ctr = stamp_ctr + 1'b1;
  endfunction

  function automatic rsp_t lfu_lookup(req_t r);
    rsp_t rsp;
    int   eff;
    int   slot;
    int   pick;
    logic hit;
    hit = 1'b0;
    slot = 0;
    eff = (cap_reg < Slots) ? int'(cap_reg) : Slots;
    for (int i = 0; i < Slots; i++) begin
      if (!hit && ent_valid[i] && ent_key[i] == r.lookup_key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    rsp.key_hit = hit;
    rsp.read_value = MissValue;
    if (r.opcode == OpGet) begin
      if (hit) begin
        rsp.read_value = ent_value[slot];
        bump_entry(slot);
      end
    end else if (eff != 0) begin
      pick = -1;
      if (hit) begin
        ent_value[slot] = r.write_value;
        bump_entry(slot);
      end else if (used_slots < eff) begin
        for (int i = 0; i < Slots; i++) begin
          if (pick < 0 && !ent_valid[i]) pick = i;
        end
        if (pick >= 0) begin
          load_entry(pick, r);
          used_slots++;
        end
      end else begin
        for (int i = 0; i < Slots; i++) begin
          if (ent_valid[i] && (pick < 0 || ent_count[i] < ent_count[pick] ||
              (ent_count[i] == ent_count[pick] && ent_stamp[i] < ent_stamp[pick]))) begin
            pick = i;
          end
        end
        if (pick >= 0) load_entry(pick, r);
      end
    end
    return rsp;
  endfunction

  task automatic send_lookup(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    int   gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    model_rsp = lfu_lookup(r);
    pending_lookups.push_back(typed ? typed_rsp : model_rsp);
  endtask

  task automatic drain_lookups();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CfgW-1:0] cap);
    drain_lookups();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    req_t  item;
    rsp_t  typed_rsp;
    drow_t row;
    int    pool_n;
    int    eff;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    burst      = 1'b0;
    hold_long  = 1'b0;
    mismatches = 0;
    used_slots = 0;
    stamp_ctr  = '0;
    cap_reg    = CapReset;
    for (int i = 0; i < Slots; i++) ent_valid[i] = 1'b0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    set_capacity(5'd16);
    for (int n = 0; n < DirRows; n++) begin
      row = dir_tab[n];
      if (row.set_cap) set_capacity(row.cap);
      item.opcode      = row.op;
      item.lookup_key  = row.key;
      item.write_value = row.val;
      typed_rsp.key_hit    = row.hit;
      typed_rsp.read_value = row.rd;
      send_lookup(item, row.typed, typed_rsp);
    end

    for (int p = 0; p < Phases; p++) begin
      set_capacity(phase_cap[p]);
      burst = (p % 3 == 2);
      if (p == 2) hold_long = 1'b1;
      eff = (phase_cap[p] < Slots) ? int'(phase_cap[p]) : Slots;
      pool_n = eff + $urandom_range(1, 6);
      for (int i = 0; i < 24; i++) begin
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 9) == 0)
            key_pool[i] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          else
            key_pool[i] = $urandom;
        end
      end
      for (int n = 0; n < PhaseReqs; n++) begin
        item.opcode      = $urandom_range(0, 1) ? OpPut : OpGet;
        item.lookup_key  = ($urandom_range(0, 7) == 0) ? $urandom
                                                      : key_pool[$urandom_range(0, pool_n - 1)];
        item.write_value = $urandom;
        send_lookup(item, 1'b0, '0);
      end
    end

    drain_lookups();
    repeat (2 * Slots + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result sink
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HoldLen) @(negedge clk);
        hold_long = 1'b0;
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CycleCap) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: hit %0b value %h", out_data.key_hit, out_data.read_value);
      end else begin
        due_rsp = pending_lookups.pop_front();
        if (out_data.key_hit !== due_rsp.key_hit ||
            out_data.read_value !== due_rsp.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit exp %0b got %0b, value exp %h got %h",
                     due_rsp.key_hit, out_data.key_hit,
                     due_rsp.read_value, out_data.read_value);
        end
      end
    end
  end

  initial cycle_cnt = 0;

endmodule

// ===== lfu_cache_table_core.f =====
design/lfuc_pkg.sv
design/lfuc_scan.sv
design/lfu_cache_table_core.sv
bench/testbench.sv
